FILE: hw/rtl/rhh_pkg.sv
// Shared types, constants and helper functions for the Robin Hood hash table.
// Depends on nothing; imported by the table core.
`timescale 1ns / 1ps

package rhh_pkg;

  // Number of slots. The home slot is taken from the low key bits, so this
  // must be a power of two.
  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 32;
  localparam int DATA_W     = 64;

  localparam logic [KEY_W-1:0] ZERO_KEY_HASH = 32'h8000_0000;
  localparam logic [IDX_W-1:0] LAST_SLOT     = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT    = CNT_W'(TABLE_SIZE);

  // Item layout on the streaming ports.
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_PUT,
    ST_SHIFT,
    ST_RESULT
  } state_t;

  // Key zero is stored as a reserved hash since a zero key marks nothing.
  function automatic logic [KEY_W-1:0] map_key(input logic [KEY_W-1:0] k);
    return (k == '0) ? ZERO_KEY_HASH : k;
  endfunction

  function automatic logic [IDX_W-1:0] home_of(input logic [KEY_W-1:0] h);
    return h[IDX_W-1:0];
  endfunction

  // Probe distance of a resident at slot idx; wraps modulo the table size.
  function automatic logic [IDX_W-1:0] dist_of(input logic [IDX_W-1:0] idx,
                                               input logic [KEY_W-1:0] h);
    return idx - h[IDX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/rhh_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// A read of the address written in the same cycle returns the new data.
`timescale 1ns / 1ps

module rhh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/robin_hood_hash_table_core.sv
// Robin Hood hash table core: control, probe sequencing and slot storage.
// Depends on rhh_pkg and on rhh_ram for the key and data stores.
`timescale 1ns / 1ps

// Usage
// The block holds a 64-slot open-addressing table with 32-bit keys and
// 64-bit data. Commands arrive on the s_ channel: put inserts or replaces,
// get looks a key up, remove deletes it by backward shifting. Every command
// item produces exactly one result item on the m_ channel carrying the
// status, the data found by a get (zero otherwise) and the slot count.
// One command is worked on at a time. The home slot is read in the accept
// cycle; after that the slots are probed one after another, since the key
// and data memories deliver one slot per cycle and the next address depends
// on the slot just read. A remove that finds its key then moves each following
// entry back by one slot until it meets an empty slot or an entry in its home
// slot, and then frees the last slot that it emptied.
// A new command is accepted as soon as the previous one has reached the
// output register, even if the receiver has not yet taken that result; a
// finished command waits in its result state while the output is stalled.
// Reset clears the occupancy bit of every slot and the count at once and
// holds the input off, so the table is empty and ready in the first cycle
// after reset.

module robin_hood_hash_table_core
  import rhh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata fields, lowest bit first: cmd[1:0], key[33:2],
  // value_in[97:34], zero padding[103:98].
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // m_tdata fields, lowest bit first: status[1:0], value_out[65:2],
  // entries_used[72:66], zero padding[79:73].
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready
);

  // Input item fields.
  logic [1:0]        s_cmd;
  logic [KEY_W-1:0]  s_key;
  logic [DATA_W-1:0] s_value;

  assign s_cmd   = s_tdata[1:0];
  assign s_key   = map_key(s_tdata[33:2]);
  assign s_value = s_tdata[97:34];

  // Control and working registers.
  state_t            state, state_next;
  cmd_t              op;
  logic [KEY_W-1:0]  cur_key, cur_key_next;
  logic [DATA_W-1:0] cur_data, cur_data_next;
  logic [IDX_W-1:0]  idx, idx_next;      // slot whose contents are on the read port
  logic [IDX_W-1:0]  cur, cur_next;      // hole being filled during a remove
  logic [IDX_W-1:0]  step, step_next;    // probe iteration
  logic [IDX_W-1:0]  pd, pd_next;        // distance of the last resident seen
  logic [IDX_W-1:0]  probe, probe_next;  // distance of the carried entry on a put
  logic [CNT_W-1:0]  used_count, used_count_next;
  status_t           res_status, res_status_next;
  logic [DATA_W-1:0] res_value, res_value_next;

  // Occupancy bits, one per slot; a clear bit reads as an empty slot.
  logic [TABLE_SIZE-1:0] valid, valid_next;
  logic                  rd_valid;

  // Memory ports.
  logic              key_we, data_we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [KEY_W-1:0]  key_wdata, key_rdata;
  logic [DATA_W-1:0] data_wdata, data_rdata;
  logic              set_valid, clr_valid;

  // Output register.
  status_t           out_status;
  logic [DATA_W-1:0] out_value;
  logic [CNT_W-1:0]  out_used;
  logic              out_valid;
  logic              out_load;

  rhh_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SIZE)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  rhh_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (waddr),
    .wdata (data_wdata),
    .raddr (raddr),
    .rdata (data_rdata)
  );

  // Decisions about the slot currently on the read port.
  logic             accept;
  logic             hit;
  logic [IDX_W-1:0] k_dist;
  logic [IDX_W-1:0] pd_eff;
  logic             look_stop;
  logic             swap;
  logic             shift_stop;

  assign accept     = s_tvalid && s_tready;
  assign hit        = rd_valid && (key_rdata == cur_key);
  assign k_dist     = dist_of(idx, key_rdata);
  assign pd_eff     = rd_valid ? k_dist : pd;
  assign look_stop  = (step > pd_eff) || (step == LAST_SLOT);
  assign swap       = probe > k_dist;
  assign shift_stop = (step == LAST_SLOT) || !rd_valid || (k_dist == '0);

  // The home slot is read while the command is accepted; afterwards the
  // port always fetches the slot after the one being examined.
  assign raddr = (state == ST_IDLE) ? home_of(s_key) : idx + 1'b1;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign out_load = (state == ST_RESULT) && (!out_valid || m_tready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (s_cmd)
            CMD_PUT:    state_next = (used_count == FULL_COUNT) ? ST_LOOK : ST_PUT;
            CMD_GET,
            CMD_REMOVE: state_next = (used_count == '0) ? ST_RESULT : ST_LOOK;
            default:    state_next = ST_RESULT;
          endcase
        end
      end
      ST_LOOK: begin
        if (hit) begin
          state_next = (op == CMD_REMOVE) ? ST_SHIFT : ST_RESULT;
        end else if (look_stop) begin
          state_next = ST_RESULT;
        end
      end
      ST_PUT: begin
        if (!rd_valid || hit || (step == LAST_SLOT)) begin
          state_next = ST_RESULT;
        end
      end
      ST_SHIFT: begin
        if (shift_stop) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory writes and working register updates.
  always_comb begin
    cur_key_next    = cur_key;
    cur_data_next   = cur_data;
    idx_next        = idx;
    cur_next        = cur;
    step_next       = step;
    pd_next         = pd;
    probe_next      = probe;
    used_count_next = used_count;
    res_status_next = res_status;
    res_value_next  = res_value;
    key_we          = 1'b0;
    data_we         = 1'b0;
    waddr           = idx;
    key_wdata       = cur_key;
    data_wdata      = cur_data;
    set_valid       = 1'b0;
    clr_valid       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cur_key_next    = s_key;
          cur_data_next   = s_value;
          idx_next        = home_of(s_key);
          step_next       = '0;
          pd_next         = '0;
          probe_next      = '0;
          res_status_next = STAT_NOT_FOUND;
          res_value_next  = '0;
        end
      end
      ST_LOOK: begin
        if (hit) begin
          res_status_next = STAT_OK;
          priority case (op)
            CMD_GET: begin
              res_value_next = data_rdata;
            end
            CMD_PUT: begin
              data_we = 1'b1;
            end
            default: begin
              cur_next  = idx;
              idx_next  = idx + 1'b1;
              step_next = '0;
            end
          endcase
        end else if (look_stop) begin
          res_status_next = (op == CMD_PUT) ? STAT_FULL : STAT_NOT_FOUND;
        end else begin
          pd_next   = pd_eff;
          step_next = step + 1'b1;
          idx_next  = idx + 1'b1;
        end
      end
      ST_PUT: begin
        if (!rd_valid) begin
          key_we          = 1'b1;
          data_we         = 1'b1;
          set_valid       = 1'b1;
          used_count_next = used_count + 1'b1;
          res_status_next = STAT_OK;
        end else if (hit) begin
          data_we         = 1'b1;
          res_status_next = STAT_OK;
        end else begin
          // The carried entry takes the slot of a resident nearer its home;
          // that resident is carried on from here.
          if (swap) begin
            key_we        = 1'b1;
            data_we       = 1'b1;
            cur_key_next  = key_rdata;
            cur_data_next = data_rdata;
            probe_next    = k_dist + 1'b1;
          end else begin
            probe_next = probe + 1'b1;
          end
          if (step == LAST_SLOT) begin
            res_status_next = STAT_FULL;
          end else begin
            step_next = step + 1'b1;
            idx_next  = idx + 1'b1;
          end
        end
      end
      ST_SHIFT: begin
        waddr = cur;
        if (shift_stop) begin
          clr_valid       = 1'b1;
          used_count_next = used_count - 1'b1;
        end else begin
          key_we     = 1'b1;
          data_we    = 1'b1;
          key_wdata  = key_rdata;
          data_wdata = data_rdata;
          cur_next   = idx;
          idx_next   = idx + 1'b1;
          step_next  = step + 1'b1;
        end
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    valid_next = valid;
    if (set_valid) begin
      valid_next[waddr] = 1'b1;
    end
    if (clr_valid) begin
      valid_next[waddr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used_count <= '0;
      valid      <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      valid      <= valid_next;
      rd_valid   <= valid_next[raddr];
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_key    <= cur_key_next;
    cur_data   <= cur_data_next;
    idx        <= idx_next;
    cur        <= cur_next;
    step       <= step_next;
    pd         <= pd_next;
    probe      <= probe_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (accept) begin
      op <= cmd_t'(s_cmd);
    end
    if (out_load) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_used   <= used_count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_W - 73)'(0), out_used, out_value, out_status};

  // The count of occupied slots always matches the occupancy bits.
  assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(used_count))
    else $error("slot count disagrees with occupancy bits");

  // The hole being closed by a remove is always an occupied slot.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> valid[cur])
    else $error("backward shift on an empty slot");

  // An accepted command always starts work in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted command was dropped");

  // A result is only presented after a command has finished.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RESULT))
    else $error("result appeared without a finished command");

endmodule
